[sv/fcuf_pkg.sv]
package fcuf_pkg;

  localparam int unsigned RX_DEPTH = 256;
  localparam int unsigned TX_DEPTH = 256;
  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned CMP_W = ((TX_AW > 8) ? TX_AW : 8) + 2;

  localparam logic [7:0] END_BYTE_RESET = 8'hFF;

  localparam logic [2:0] KIND_RX_BYTE   = 3'd0;
  localparam logic [2:0] KIND_HOST_READ = 3'd1;
  localparam logic [2:0] KIND_CMD_BYTE  = 3'd2;
  localparam logic [2:0] KIND_TX_TAKE   = 3'd3;
  localparam logic [2:0] KIND_LINE_ERR  = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_in;
    logic [7:0] cmd_length;
    logic       cmd_first;
    logic       cmd_last;
  } item_t;

  typedef struct packed {
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        cmd_accepted;
    logic        line_valid;
    logic [7:0]  line_byte;
    logic [7:0]  rx_level;
    logic [7:0]  tx_level;
    logic [31:0] rx_total;
    logic [31:0] rx_overflows;
    logic [31:0] tx_total;
    logic [31:0] tx_rejects;
    logic [31:0] line_errors;
  } result_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic put_end;
  } ctrl_t;

  typedef struct packed {
    logic need_end;
  } stat_t;

endpackage

[sv/fcuf_ctrl.sv]
module fcuf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  fcuf_pkg::stat_t stat_i,
  output fcuf_pkg::ctrl_t ctrl_o,
  output logic           busy_o,
  output logic           done_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_END1 = 3'd2;
  localparam logic [2:0] S_END2 = 3'd3;
  localparam logic [2:0] S_END3 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_EXEC;
      S_EXEC: state_d = stat_i.need_end ? S_END1 : S_DONE;
      S_END1: state_d = S_END2;
      S_END2: state_d = S_END3;
      S_END3: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctrl_o.load    = (state_q == S_IDLE) && start_i;
  assign ctrl_o.exec    = (state_q == S_EXEC);
  assign ctrl_o.put_end = (state_q == S_END1) || (state_q == S_END2) ||
                          (state_q == S_END3);
  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

[sv/fcuf_dp.sv]
module fcuf_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fcuf_pkg::ctrl_t   ctrl_i,
  input  fcuf_pkg::item_t   item_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  output fcuf_pkg::stat_t   stat_o,
  output fcuf_pkg::result_t result_o
);

  localparam int unsigned RAW = fcuf_pkg::RX_AW;
  localparam int unsigned TAW = fcuf_pkg::TX_AW;
  localparam int unsigned CW  = fcuf_pkg::CMP_W;

  logic [7:0] rx_mem [fcuf_pkg::RX_DEPTH];
  logic [7:0] tx_mem [fcuf_pkg::TX_DEPTH];

  fcuf_pkg::item_t item_q;
  logic [7:0]  end_byte_q;
  logic [RAW-1:0] rx_wr_q, rx_rd_q;
  logic [TAW-1:0] tx_wr_q, tx_rd_q;
  logic        cmd_open_q;
  logic [7:0]  room_q;
  logic [31:0] rx_total_q, rx_ovf_q, tx_total_q, tx_rej_q, line_err_q;
  logic        rd_valid_q, acc_q, ln_valid_q;
  logic [7:0]  rx_rdata_q, tx_rdata_q;

  logic [RAW-1:0] rx_next, rx_rd_next, rx_lvl;
  logic [TAW-1:0] tx_next, tx_rd_next, tx_lvl, tx_free;
  logic        is_rx, is_rd, is_cmd, is_take, is_err;
  logic        rx_nonempty, tx_nonempty;
  logic        adm_ok, open_eff, cmd_wr, cmd_close, cmd_reject;
  logic [7:0]  room_eff, room_after;

  assign rx_next    = (rx_wr_q == RAW'(fcuf_pkg::RX_DEPTH - 1)) ? '0 : rx_wr_q + 1'b1;
  assign rx_rd_next = (rx_rd_q == RAW'(fcuf_pkg::RX_DEPTH - 1)) ? '0 : rx_rd_q + 1'b1;
  assign tx_next    = (tx_wr_q == TAW'(fcuf_pkg::TX_DEPTH - 1)) ? '0 : tx_wr_q + 1'b1;
  assign tx_rd_next = (tx_rd_q == TAW'(fcuf_pkg::TX_DEPTH - 1)) ? '0 : tx_rd_q + 1'b1;

  assign rx_lvl = (rx_wr_q >= rx_rd_q) ? (rx_wr_q - rx_rd_q) :
                  RAW'((RAW + 1)'(fcuf_pkg::RX_DEPTH) - {1'b0, rx_rd_q} + {1'b0, rx_wr_q});
  assign tx_lvl = (tx_wr_q >= tx_rd_q) ? (tx_wr_q - tx_rd_q) :
                  TAW'((TAW + 1)'(fcuf_pkg::TX_DEPTH) - {1'b0, tx_rd_q} + {1'b0, tx_wr_q});
  assign tx_free = TAW'(fcuf_pkg::TX_DEPTH - 1) - tx_lvl;

  assign rx_nonempty = (rx_wr_q != rx_rd_q);
  assign tx_nonempty = (tx_wr_q != tx_rd_q);

  assign is_rx   = ctrl_i.exec && (item_q.kind == fcuf_pkg::KIND_RX_BYTE);
  assign is_rd   = ctrl_i.exec && (item_q.kind == fcuf_pkg::KIND_HOST_READ);
  assign is_cmd  = ctrl_i.exec && (item_q.kind == fcuf_pkg::KIND_CMD_BYTE);
  assign is_take = ctrl_i.exec && (item_q.kind == fcuf_pkg::KIND_TX_TAKE);
  assign is_err  = ctrl_i.exec && (item_q.kind == fcuf_pkg::KIND_LINE_ERR);

  assign adm_ok = (item_q.cmd_length != 8'd0) &&
                  (CW'(item_q.cmd_length) <= CW'(fcuf_pkg::TX_DEPTH - 4)) &&
                  (CW'(tx_free) >= CW'(item_q.cmd_length) + CW'(3));
  assign cmd_reject = item_q.cmd_first && (item_q.cmd_length != 8'd0) && !adm_ok;
  assign open_eff   = item_q.cmd_first ? adm_ok : cmd_open_q;
  assign room_eff   = item_q.cmd_first ? (adm_ok ? item_q.cmd_length : 8'd0) : room_q;
  assign cmd_wr     = open_eff && (room_eff != 8'd0);
  assign room_after = room_eff - 8'd1;
  assign cmd_close  = cmd_wr && (item_q.cmd_last || (room_after == 8'd0));

  assign stat_o.need_end = is_cmd && cmd_close;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_rx) begin
      rx_mem[rx_wr_q] <= item_q.data_in;
    end
    if (is_rd) begin
      rx_rdata_q <= rx_mem[rx_rd_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_cmd && cmd_wr) begin
      tx_mem[tx_wr_q] <= item_q.data_in;
    end else if (ctrl_i.put_end) begin
      tx_mem[tx_wr_q] <= end_byte_q;
    end
    if (is_take) begin
      tx_rdata_q <= tx_mem[tx_rd_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_byte_q <= fcuf_pkg::END_BYTE_RESET;
      rx_wr_q    <= '0;
      rx_rd_q    <= '0;
      tx_wr_q    <= '0;
      tx_rd_q    <= '0;
      cmd_open_q <= 1'b0;
      room_q     <= '0;
      rx_total_q <= '0;
      rx_ovf_q   <= '0;
      tx_total_q <= '0;
      tx_rej_q   <= '0;
      line_err_q <= '0;
      rd_valid_q <= 1'b0;
      acc_q      <= 1'b0;
      ln_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        end_byte_q <= cfg_wdata_i;
      end
      if (ctrl_i.exec) begin
        rd_valid_q <= is_rd && rx_nonempty;
        acc_q      <= is_cmd && cmd_wr;
        ln_valid_q <= is_take && tx_nonempty;
      end
      if (is_rx) begin
        if (rx_next == rx_rd_q) begin
          rx_ovf_q <= rx_ovf_q + 32'd1;
          rx_rd_q  <= rx_wr_q;
        end
        rx_wr_q    <= rx_next;
        rx_total_q <= rx_total_q + 32'd1;
      end
      if (is_rd && rx_nonempty) begin
        rx_rd_q <= rx_rd_next;
      end
      if (is_err) begin
        rx_rd_q    <= rx_wr_q;
        line_err_q <= line_err_q + 32'd1;
      end
      if (is_cmd) begin
        if (cmd_reject) begin
          tx_rej_q <= tx_rej_q + 32'd1;
        end
        if (item_q.cmd_first || cmd_wr) begin
          cmd_open_q <= cmd_wr && !cmd_close;
          room_q     <= (cmd_wr && !cmd_close) ? room_after : 8'd0;
        end
        if (cmd_wr) begin
          tx_wr_q <= tx_next;
        end
      end
      if (ctrl_i.put_end) begin
        tx_wr_q <= tx_next;
      end
      if (is_take && tx_nonempty) begin
        tx_rd_q    <= tx_rd_next;
        tx_total_q <= tx_total_q + 32'd1;
      end
    end
  end

  assign result_o.read_valid   = rd_valid_q;
  assign result_o.read_byte    = rd_valid_q ? rx_rdata_q : 8'd0;
  assign result_o.cmd_accepted = acc_q;
  assign result_o.line_valid   = ln_valid_q;
  assign result_o.line_byte    = ln_valid_q ? tx_rdata_q : 8'd0;
  assign result_o.rx_level     = 8'(rx_lvl);
  assign result_o.tx_level     = 8'(tx_lvl);
  assign result_o.rx_total     = rx_total_q;
  assign result_o.rx_overflows = rx_ovf_q;
  assign result_o.tx_total     = tx_total_q;
  assign result_o.tx_rejects   = tx_rej_q;
  assign result_o.line_errors  = line_err_q;

endmodule

[sv/framed_command_uart_fifos.sv]
// Receive and transmit byte rings for a framed command serial port.
// Command channel: present an item on item_i with start_i high; it is taken
// at a clock edge where busy_o is low. busy_o stays high until the result
// has been shown. The result appears on result_o for exactly one cycle with
// done_o high; the receiver cannot stall and must take it in that cycle.
// From accept, the block passes through an execute state and then shows
// done_o; a command byte that closes its command first passes through one
// end state per end byte (three end bytes are written one per cycle through
// the single write port of the transmit memory). A new item can be accepted
// the cycle after done_o. Ring reads go through a registered memory port,
// which is why the result is shown in the state after execution.
// The end byte register resets to 0xFF; the user must write it through
// cfg_we_i / cfg_wdata_i only while the block is idle; this is not enforced.
// Reset empties both rings, closes any open command and clears all five
// event counters; ring contents are not cleared and no clearing pass runs.
module framed_command_uart_fifos (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fcuf_pkg::item_t   item_i,
  output logic              busy_o,
  output logic              done_o,
  output fcuf_pkg::result_t result_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);

  fcuf_pkg::ctrl_t ctrl;
  fcuf_pkg::stat_t stat;

  fcuf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  fcuf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_o      (stat),
    .result_o    (result_o)
  );

endmodule

[sv/fcuf_chk.sv]
module fcuf_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input fcuf_pkg::result_t result_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !done_o)
    else $error("accepted item did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("done strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("done shown while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0({result_o.read_valid, result_o.cmd_accepted,
                         result_o.line_valid}))
    else $error("more than one event flag in a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.line_valid |-> result_o.tx_total != $past(result_o.tx_total, 2))
    else $error("transmit take not counted");

endmodule

bind framed_command_uart_fifos fcuf_chk u_fcuf_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

[tb/testbench.sv]
module testbench;
  import fcuf_pkg::*;

  localparam logic [2:0] KIND_SPARE = 3'd5;
  localparam int MAX_CMD_LEN = int'(TX_DEPTH) - 4;
  localparam int END_COPIES = 3;

  typedef enum logic [1:0] {FEED_ITEM, FEED_END_BYTE, FEED_HOLD, FEED_PACE} feed_op_e;

  typedef struct {
    feed_op_e   op;
    item_t      item;
    logic [7:0] value;
  } feed_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  item_t      item_i = '0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic       busy_o;
  logic       done_o;
  result_t    result_o;

  feed_t   item_feed[$];
  result_t awaited_results[$];
  int      sender_idle_pct = 0;
  int      queued_items = 0;
  int      items_taken = 0;
  int      results_checked = 0;
  int      end_byte_writes = 0;
  int      mismatches = 0;

  logic [7:0]       rx_mem [RX_DEPTH];
  logic [7:0]       tx_mem [TX_DEPTH];
  logic [RX_AW-1:0] rx_wr = '0;
  logic [RX_AW-1:0] rx_rd = '0;
  logic [TX_AW-1:0] tx_wr = '0;
  logic [TX_AW-1:0] tx_rd = '0;
  logic             cmd_open = 1'b0;
  logic [7:0]       cmd_room = '0;
  logic [7:0]       tail_byte = END_BYTE_RESET;
  logic [31:0]      cnt_rx_total = '0;
  logic [31:0]      cnt_rx_overflows = '0;
  logic [31:0]      cnt_tx_total = '0;
  logic [31:0]      cnt_tx_rejects = '0;
  logic [31:0]      cnt_line_errors = '0;

  framed_command_uart_fifos dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic result_t advance_rings(input item_t it);
    result_t          r;
    logic [RX_AW-1:0] rx_next;
    logic [TX_AW-1:0] tx_lvl;
    int               free_room;
    r = '0;
    case (it.kind)
      KIND_RX_BYTE: begin
        rx_next = rx_wr + 1'b1;
        if (rx_next == rx_rd) begin
          cnt_rx_overflows++;
          rx_rd = rx_wr;
        end
        rx_mem[rx_wr] = it.data_in;
        rx_wr = rx_next;
        cnt_rx_total++;
      end
      KIND_HOST_READ: begin
        if (rx_wr != rx_rd) begin
          r.read_valid = 1'b1;
          r.read_byte = rx_mem[rx_rd];
          rx_rd = rx_rd + 1'b1;
        end
      end
      KIND_CMD_BYTE: begin
        if (it.cmd_first) begin
          cmd_open = 1'b0;
          cmd_room = '0;
          tx_lvl = tx_wr - tx_rd;
          free_room = int'(TX_DEPTH) - 1 - int'(tx_lvl);
          if (it.cmd_length != 0) begin
            if (int'(it.cmd_length) > MAX_CMD_LEN ||
                free_room < int'(it.cmd_length) + END_COPIES) begin
              cnt_tx_rejects++;
            end else begin
              cmd_open = 1'b1;
              cmd_room = it.cmd_length;
            end
          end
        end
        if (cmd_open && cmd_room != 0) begin
          r.cmd_accepted = 1'b1;
          tx_mem[tx_wr] = it.data_in;
          tx_wr = tx_wr + 1'b1;
          cmd_room = cmd_room - 1'b1;
          if (it.cmd_last || cmd_room == 0) begin
            for (int k = 0; k < END_COPIES; k++) begin
              tx_mem[tx_wr] = tail_byte;
              tx_wr = tx_wr + 1'b1;
            end
            cmd_open = 1'b0;
            cmd_room = '0;
          end
        end
      end
      KIND_TX_TAKE: begin
        if (tx_wr != tx_rd) begin
          r.line_valid = 1'b1;
          r.line_byte = tx_mem[tx_rd];
          tx_rd = tx_rd + 1'b1;
          cnt_tx_total++;
        end
      end
      KIND_LINE_ERR: begin
        rx_rd = rx_wr;
        cnt_line_errors++;
      end
      default: ;
    endcase
    r.rx_level = 8'(rx_wr - rx_rd);
    r.tx_level = 8'(tx_wr - tx_rd);
    r.rx_total = cnt_rx_total;
    r.rx_overflows = cnt_rx_overflows;
    r.tx_total = cnt_tx_total;
    r.tx_rejects = cnt_tx_rejects;
    r.line_errors = cnt_line_errors;
    return r;
  endfunction

  always @(posedge clk_i) begin : drive
    logic       go;
    item_t      nxt_item;
    logic       nxt_we;
    logic [7:0] nxt_wdata;
    feed_t      head;
    go = 1'b0;
    nxt_item = item_i;
    nxt_we = 1'b0;
    nxt_wdata = cfg_wdata_i;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        awaited_results.push_back(advance_rings(item_i));
        items_taken++;
      end
      if (start_i && busy_o) begin
        go = 1'b1;
      end else if (item_feed.size() > 0) begin
        head = item_feed[0];
        case (head.op)
          FEED_ITEM: begin
            if ($urandom_range(99) >= sender_idle_pct) begin
              go = 1'b1;
              nxt_item = head.item;
              void'(item_feed.pop_front());
            end
          end
          FEED_END_BYTE: begin
            if (awaited_results.size() == 0 && !busy_o) begin
              nxt_we = 1'b1;
              nxt_wdata = head.value;
              tail_byte = head.value;
              end_byte_writes++;
              void'(item_feed.pop_front());
            end
          end
          FEED_HOLD: begin
            if (awaited_results.size() == 0) void'(item_feed.pop_front());
          end
          default: begin
            sender_idle_pct = int'(head.value);
            void'(item_feed.pop_front());
          end
        endcase
      end
    end
    start_i <= go;
    item_i <= nxt_item;
    cfg_we_i <= nxt_we;
    cfg_wdata_i <= nxt_wdata;
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        check_field("read_valid", want.read_valid, result_o.read_valid);
        check_field("read_byte", want.read_byte, result_o.read_byte);
        check_field("cmd_accepted", want.cmd_accepted, result_o.cmd_accepted);
        check_field("line_valid", want.line_valid, result_o.line_valid);
        check_field("line_byte", want.line_byte, result_o.line_byte);
        check_field("rx_level", want.rx_level, result_o.rx_level);
        check_field("tx_level", want.tx_level, result_o.tx_level);
        check_field("rx_total", want.rx_total, result_o.rx_total);
        check_field("rx_overflows", want.rx_overflows, result_o.rx_overflows);
        check_field("tx_total", want.tx_total, result_o.tx_total);
        check_field("tx_rejects", want.tx_rejects, result_o.tx_rejects);
        check_field("line_errors", want.line_errors, result_o.line_errors);
      end
    end
  end

  task automatic push_op(input feed_op_e op, input logic [7:0] value);
    feed_t f;
    f.op = op;
    f.item = '0;
    f.value = value;
    item_feed.push_back(f);
  endtask

  task automatic push_item(input logic [2:0] kind, input logic [7:0] data,
                           input logic [7:0] len, input logic first, input logic last);
    feed_t f;
    f.op = FEED_ITEM;
    f.item.kind = kind;
    f.item.data_in = data;
    f.item.cmd_length = len;
    f.item.cmd_first = first;
    f.item.cmd_last = last;
    f.value = '0;
    item_feed.push_back(f);
    queued_items++;
  endtask

  task automatic send_command(input int len, input int count, input bit mark_last);
    for (int i = 0; i < count; i++) begin
      push_item(KIND_CMD_BYTE, 8'($urandom), 8'(len), i == 0, mark_last && i == count - 1);
    end
  endtask

  task automatic add_traffic(input int target);
    int stop_at;
    int pick;
    int variant;
    int len;
    int n;
    stop_at = queued_items + target;
    while (queued_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 28) begin
        len = ($urandom_range(24) == 0) ? $urandom_range(255, 248) : $urandom_range(12, 1);
        n = (len > MAX_CMD_LEN) ? $urandom_range(4, 1) : len;
        variant = $urandom_range(9);
        if (variant < 4) begin
          send_command(len, n, 1'b1);
        end else if (variant < 6) begin
          send_command(len, n, 1'b0);
        end else if (variant < 8) begin
          send_command(len, $urandom_range(n, 1), 1'b1);
        end else if (variant < 9) begin
          send_command(len, $urandom_range(n, 1), 1'b0);
        end else begin
          send_command(len, n, 1'b1);
          repeat ($urandom_range(3, 1))
            push_item(KIND_CMD_BYTE, 8'($urandom), 8'($urandom), 1'b0, 1'($urandom));
        end
      end else if (pick < 48) begin
        n = ($urandom_range(39) == 0) ? $urandom_range(300, 256) : $urandom_range(16, 1);
        repeat (n)
          push_item(KIND_RX_BYTE, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 66) begin
        repeat ($urandom_range(16, 1))
          push_item(KIND_HOST_READ, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 84) begin
        repeat ($urandom_range(14, 1))
          push_item(KIND_TX_TAKE, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 89) begin
        push_item(KIND_LINE_ERR, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 96) begin
        push_item(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        push_op(FEED_HOLD, '0);
      end
    end
  endtask

  initial begin
    push_op(FEED_END_BYTE, 8'h00);
    push_item(KIND_HOST_READ, 8'hFF, 8'hFF, 1'b1, 1'b1);
    push_item(KIND_TX_TAKE, 8'hFF, 8'hFF, 1'b1, 1'b1);
    push_item(KIND_RX_BYTE, 8'h00, 8'h00, 1'b0, 1'b0);
    push_item(KIND_RX_BYTE, 8'hFF, 8'hFF, 1'b1, 1'b1);
    repeat (3) push_item(KIND_HOST_READ, 8'h00, 8'h00, 1'b0, 1'b0);
    push_item(KIND_CMD_BYTE, 8'h5A, 8'd0, 1'b1, 1'b0);
    push_item(KIND_CMD_BYTE, 8'h11, 8'd9, 1'b0, 1'b0);
    push_item(KIND_CMD_BYTE, 8'h22, 8'd255, 1'b1, 1'b0);
    push_item(KIND_CMD_BYTE, 8'h23, 8'd253, 1'b1, 1'b1);
    push_item(KIND_CMD_BYTE, 8'hFF, 8'd1, 1'b1, 1'b0);
    push_item(KIND_CMD_BYTE, 8'h00, 8'd4, 1'b1, 1'b0);
    push_item(KIND_CMD_BYTE, 8'h80, 8'd0, 1'b0, 1'b1);
    push_item(KIND_CMD_BYTE, 8'h33, 8'd3, 1'b1, 1'b0);
    push_item(KIND_CMD_BYTE, 8'h44, 8'd2, 1'b1, 1'b0);
    push_item(KIND_CMD_BYTE, 8'h55, 8'd7, 1'b0, 1'b0);
    push_item(KIND_CMD_BYTE, 8'h66, 8'd2, 1'b0, 1'b1);
    repeat (6) push_item(KIND_TX_TAKE, 8'h00, 8'h00, 1'b0, 1'b0);
    push_item(KIND_RX_BYTE, 8'hA5, 8'h01, 1'b0, 1'b1);
    push_item(KIND_LINE_ERR, 8'hFF, 8'hFF, 1'b1, 1'b1);
    push_item(KIND_HOST_READ, 8'h00, 8'h00, 1'b0, 1'b0);
    push_item(KIND_SPARE, 8'h00, 8'h00, 1'b1, 1'b0);
    push_item(KIND_SPARE + 3'd2, 8'hFF, 8'hFF, 1'b1, 1'b1);

    push_op(FEED_PACE, 8'd6);
    push_op(FEED_END_BYTE, 8'($urandom_range(254, 1)));
    add_traffic(350);
    push_op(FEED_PACE, 8'd45);
    push_op(FEED_END_BYTE, 8'hFF);
    add_traffic(350);
    push_op(FEED_PACE, 8'd0);
    push_op(FEED_END_BYTE, 8'($urandom));
    repeat (258) push_item(KIND_RX_BYTE, 8'($urandom), 8'($urandom), 1'b0, 1'b0);
    add_traffic(300);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (!(item_feed.size() == 0 && !start_i && awaited_results.size() == 0 && !busy_o));
    repeat (8) @(posedge clk_i);

    $display("run covered %0d items, %0d results checked, %0d end byte writes",
             items_taken, results_checked, end_byte_writes);
    $display("events: %0d rx overflows, %0d command rejects, %0d line errors, %0d bytes sent",
             cnt_rx_overflows, cnt_tx_rejects, cnt_line_errors, cnt_tx_total);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
sv/fcuf_pkg.sv
sv/fcuf_ctrl.sv
sv/fcuf_dp.sv
sv/framed_command_uart_fifos.sv
sv/fcuf_chk.sv
tb/testbench.sv
